[rtl/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared constants, register indexes, reason codes and control types for the
// plane table classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

    // field widths of the channels
    localparam int XY_W       = 13;
    localparam int ATTR_W     = 16;
    localparam int REASON_W   = 3;
    localparam int OUT_AREA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // coordinate and area sizing
    localparam int COORD_BITS = 13;
    localparam int AREA_BITS  = 32;

    // side lengths: sqrt of dx^2 + dy^2 with |dx|, |dy| < 2^COORD_BITS
    localparam int SIDE_W = COORD_BITS + 1;
    localparam int DIST_W = 2 * COORD_BITS + 1;
    // signed Heron terms; perimeter needs SIDE_W + 2 magnitude bits
    localparam int TERM_W = SIDE_W + 3;
    localparam int MAG_W  = TERM_W - 1;

    // shared multiplier and root unit
    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int SQ_W        = 62;
    localparam int SQ_ROOT_W   = SQ_W / 2;
    localparam int SQ_REM_W    = SQ_ROOT_W + 2;
    localparam int SQ_CNT_W    = 5;
    localparam int SIDE_ITERS  = SIDE_W;
    localparam int HERON_ITERS = SQ_ROOT_W;
    localparam int SIDE_SHIFT  = SQ_W - 2 * SIDE_ITERS;
    localparam int TRI_W       = SQ_ROOT_W - 2;

    // area accumulator, one bit of headroom over the widest addend
    localparam int ACC_W = ((AREA_BITS > TRI_W) ? AREA_BITS : TRI_W) + 1;
    localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

    // extent ratio compare widths
    localparam int RATIO_W = 25;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_NORMAL_Z  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATIO     = 3'd5;

    // reject reasons
    localparam logic [REASON_W-1:0] REASON_NONE   = 3'd0;
    localparam logic [REASON_W-1:0] REASON_TILT   = 3'd1;
    localparam logic [REASON_W-1:0] REASON_HEIGHT = 3'd2;
    localparam logic [REASON_W-1:0] REASON_AREA   = 3'd3;
    localparam logic [REASON_W-1:0] REASON_RATIO  = 3'd4;

    // fan triangle sides
    localparam logic [1:0] SIDE_A = 2'd0;   // anchor to previous
    localparam logic [1:0] SIDE_B = 2'd1;   // anchor to current
    localparam logic [1:0] SIDE_C = 2'd2;   // previous to current

    // controller to datapath
    typedef struct packed {
        logic       take;
        logic [1:0] side;
        logic       sq_x;
        logic       sq_y;
        logic       side_root;
        logic       side_save;
        logic       terms;
        logic       prod1;
        logic       prod2;
        logic       prod3;
        logic       heron_root;
        logic       accum;
        logic       advance;
        logic       verdict;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic new_plane;
        logic need_tri;
        logic last;
        logic sq_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[rtl/ptc_point_if.sv]
// ----------------------------------------------------------------------------
// ptc_point_if
// Hull point channel with plane attributes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptc_point_if;
    import ptc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [XY_W-1:0]   point_x;
    logic signed [XY_W-1:0]   point_y;
    logic                     first_point;
    logic                     last_point;
    logic signed [ATTR_W-1:0] normal_z;
    logic signed [ATTR_W-1:0] centre_z;
    logic [ATTR_W-1:0]        extent_one;
    logic [ATTR_W-1:0]        extent_two;

    modport source (
        output valid, point_x, point_y, first_point, last_point,
               normal_z, centre_z, extent_one, extent_two,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, first_point, last_point,
               normal_z, centre_z, extent_one, extent_two,
        output ready
    );
endinterface

`default_nettype wire

[rtl/ptc_verdict_if.sv]
// ----------------------------------------------------------------------------
// ptc_verdict_if
// Verdict channel: accept flag, reason and hull area.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptc_verdict_if;
    import ptc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  accepted;
    logic [REASON_W-1:0]   reject_reason;
    logic [OUT_AREA_W-1:0] plane_area;

    modport source (
        output valid, accepted, reject_reason, plane_area,
        input  ready
    );
    modport sink (
        input  valid, accepted, reject_reason, plane_area,
        output ready
    );
endinterface

`default_nettype wire

[rtl/ptc_cfg_if.sv]
// ----------------------------------------------------------------------------
// ptc_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptc_cfg_if;
    import ptc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] write_data;

    modport source (
        output valid, reg_index, write_data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, write_data,
        output ready
    );
endinterface

`default_nettype wire

[rtl/ptc_sqrt.sv]
// ----------------------------------------------------------------------------
// ptc_sqrt
// Iterative floor square root, one result bit per cycle. The radicand is
// left aligned; iters sets how many result bits are produced.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_sqrt
    import ptc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [SQ_W-1:0]      rad,
    input  wire logic [SQ_CNT_W-1:0]  iters,
    output logic                      done,
    output logic [SQ_ROOT_W-1:0]      root
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [SQ_CNT_W-1:0]  cnt_reg;
    logic [SQ_W-1:0]      rad_reg;
    logic [SQ_REM_W-1:0]  rem_reg;
    logic [SQ_ROOT_W-1:0] root_reg;

    logic [SQ_REM_W+1:0]  rem_sh;
    logic [SQ_REM_W+1:0]  trial;
    logic [SQ_REM_W+1:0]  diff;
    logic                 fits;

    // one restoring step
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial  = (SQ_REM_W+2)'({root_reg, 2'b01});
        fits   = rem_sh >= trial;
        diff   = rem_sh - trial;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= iters;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != SQ_CNT_W'(1);
            done_reg <= cnt_reg == SQ_CNT_W'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (fits)
            begin
                rem_reg  <= diff[SQ_REM_W-1:0];
                root_reg <= {root_reg[SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[SQ_REM_W-1:0];
                root_reg <= {root_reg[SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

[rtl/ptc_dp.sv]
// ----------------------------------------------------------------------------
// ptc_dp
// Datapath: point and plane registers, configuration registers, shared
// multiplier, root unit, area accumulator and verdict register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_dp
    import ptc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    input  wire logic signed [XY_W-1:0]   point_x,
    input  wire logic signed [XY_W-1:0]   point_y,
    input  wire logic                     first_point,
    input  wire logic                     last_point,
    input  wire logic signed [ATTR_W-1:0] normal_z,
    input  wire logic signed [ATTR_W-1:0] centre_z,
    input  wire logic [ATTR_W-1:0]        extent_one,
    input  wire logic [ATTR_W-1:0]        extent_two,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                     out_ready,
    output status_t                       status,
    output logic                          out_valid,
    output logic                          accepted,
    output logic [REASON_W-1:0]           reject_reason,
    output logic [OUT_AREA_W-1:0]         plane_area
);

    // configuration
    logic [14:0]            min_normal_z_reg;
    logic signed [13:0]     camera_offset_reg;
    logic signed [15:0]     min_height_reg;
    logic signed [15:0]     max_height_reg;
    logic [31:0]            min_area_reg;
    logic [8:0]             min_ratio_reg;

    // plane state
    logic signed [COORD_BITS-1:0] anchor_x_reg, anchor_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic [1:0]                   points_reg;
    logic [AREA_BITS-1:0]         area_reg;
    logic signed [ATTR_W-1:0]     held_nz_reg, held_cz_reg;
    logic [ATTR_W-1:0]            held_e1_reg, held_e2_reg;
    logic                         new_reg, need_reg, last_reg;

    // triangle work registers
    logic [SIDE_W-1:0]  side_a_reg, side_b_reg, side_c_reg;
    logic [PROD_W-1:0]  mul_reg;
    logic [MUL_W-1:0]   hold_reg;
    logic [MAG_W-1:0]   s_reg, m1_reg, m2_reg, m3_reg;
    logic               zero_reg, neg_reg;

    // verdict register
    logic                  out_valid_reg;
    logic                  acc_out_reg;
    logic [REASON_W-1:0]   reason_out_reg;
    logic [OUT_AREA_W-1:0] area_out_reg;

    logic signed [COORD_BITS-1:0] px, py, x0, y0, x1, y1;
    logic signed [COORD_BITS:0]   dx, dy;
    logic [COORD_BITS-1:0]        adx, ady;
    logic                         new_plane;
    logic [MUL_W-1:0]             mul_a, mul_b;
    logic [PROD_W-1:0]            product;
    logic [DIST_W-1:0]            dist_sq;
    logic                         sq_start;
    logic [SQ_W-1:0]              sq_rad;
    logic [SQ_CNT_W-1:0]          sq_iters;
    logic                         sq_done;
    logic [SQ_ROOT_W-1:0]         sq_root;
    logic signed [TERM_W-1:0]     ea, eb, ec, ts, t1, t2, t3, a1, a2, a3;
    logic [ACC_W-1:0]             area_sum;
    logic [16:0]                  abs_nz;
    logic signed [16:0]           nz_wide, height;
    logic [ATTR_W-1:0]            ext_min, ext_max;
    logic [RATIO_W-1:0]           ratio_lhs, ratio_rhs;
    logic [REASON_W-1:0]          reason;

    assign px        = point_x[COORD_BITS-1:0];
    assign py        = point_y[COORD_BITS-1:0];
    assign new_plane = first_point || (points_reg == 2'd0);

    // endpoints of the side being measured
    always_comb
    begin
        unique case (cmd.side)
            SIDE_A:
            begin
                x0 = anchor_x_reg; y0 = anchor_y_reg; x1 = prev_x_reg; y1 = prev_y_reg;
            end
            SIDE_B:
            begin
                x0 = anchor_x_reg; y0 = anchor_y_reg; x1 = cur_x_reg; y1 = cur_y_reg;
            end
            SIDE_C:
            begin
                x0 = prev_x_reg; y0 = prev_y_reg; x1 = cur_x_reg; y1 = cur_y_reg;
            end
            default:
            begin
                x0 = prev_x_reg; y0 = prev_y_reg; x1 = cur_x_reg; y1 = cur_y_reg;
            end
        endcase
        dx  = (COORD_BITS+1)'(x1) - (COORD_BITS+1)'(x0);
        dy  = (COORD_BITS+1)'(y1) - (COORD_BITS+1)'(y0);
        adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.sq_x)
        begin
            mul_a = MUL_W'(adx);
            mul_b = MUL_W'(adx);
        end
        else if (cmd.sq_y)
        begin
            mul_a = MUL_W'(ady);
            mul_b = MUL_W'(ady);
        end
        else if (cmd.prod1)
        begin
            mul_a = MUL_W'(s_reg);
            mul_b = MUL_W'(m1_reg);
        end
        else if (cmd.prod2)
        begin
            mul_a = MUL_W'(m2_reg);
            mul_b = MUL_W'(m3_reg);
        end
        else if (cmd.prod3)
        begin
            mul_a = hold_reg;
            mul_b = mul_reg[MUL_W-1:0];
        end
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    // root unit operands
    assign dist_sq  = DIST_W'(hold_reg) + DIST_W'(mul_reg);
    assign sq_start = cmd.side_root || cmd.heron_root;
    assign sq_rad   = cmd.side_root ? (SQ_W'(dist_sq) << SIDE_SHIFT)
                    : ((zero_reg || neg_reg) ? '0 : mul_reg[SQ_W-1:0]);
    assign sq_iters = cmd.side_root ? SQ_CNT_W'(SIDE_ITERS) : SQ_CNT_W'(HERON_ITERS);

    ptc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (sq_rad),
        .iters (sq_iters),
        .done  (sq_done),
        .root  (sq_root)
    );

    // Heron terms from the three sides
    always_comb
    begin
        ea = signed'(TERM_W'(side_a_reg));
        eb = signed'(TERM_W'(side_b_reg));
        ec = signed'(TERM_W'(side_c_reg));
        ts = ea + eb + ec;
        t1 = eb + ec - ea;
        t2 = ea + ec - eb;
        t3 = ea + eb - ec;
        a1 = t1[TERM_W-1] ? -t1 : t1;
        a2 = t2[TERM_W-1] ? -t2 : t2;
        a3 = t3[TERM_W-1] ? -t3 : t3;
    end

    // saturating accumulate of the triangle area
    always_comb
    begin
        area_sum = ACC_W'(area_reg) + ACC_W'(sq_root[SQ_ROOT_W-1:2]);
    end

    // verdict tests, first failing test wins
    always_comb
    begin
        nz_wide   = 17'(held_nz_reg);
        abs_nz    = nz_wide[16] ? 17'(-nz_wide) : 17'(nz_wide);
        height    = 17'(camera_offset_reg) + 17'(held_cz_reg);
        ext_min   = (held_e1_reg > held_e2_reg) ? held_e2_reg : held_e1_reg;
        ext_max   = (held_e1_reg > held_e2_reg) ? held_e1_reg : held_e2_reg;
        ratio_lhs = RATIO_W'({ext_min, 8'h00});
        ratio_rhs = RATIO_W'(min_ratio_reg) * RATIO_W'(ext_max);
        if (abs_nz < 17'(min_normal_z_reg))
            reason = REASON_TILT;
        else if (height < 17'(min_height_reg) || height > 17'(max_height_reg))
            reason = REASON_HEIGHT;
        else if (ACC_W'(area_reg) < ACC_W'(min_area_reg))
            reason = REASON_AREA;
        else if (ext_max == '0 || ratio_lhs < ratio_rhs)
            reason = REASON_RATIO;
        else
            reason = REASON_NONE;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_normal_z_reg  <= 15'd31164;
            camera_offset_reg <= '0;
            min_height_reg    <= 16'sd563;
            max_height_reg    <= 16'sd1126;
            min_area_reg      <= 32'd314573;
            min_ratio_reg     <= 9'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_NORMAL_Z:  min_normal_z_reg  <= cfg_data[14:0];
                REG_CAMERA_OFFSET: camera_offset_reg <= cfg_data[13:0];
                REG_MIN_HEIGHT:    min_height_reg    <= cfg_data[15:0];
                REG_MAX_HEIGHT:    max_height_reg    <= cfg_data[15:0];
                REG_MIN_AREA:      min_area_reg      <= cfg_data[31:0];
                REG_MIN_RATIO:     min_ratio_reg     <= cfg_data[8:0];
                default:           ;
            endcase
        end
    end

    // plane control state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg    <= '0;
            area_reg      <= '0;
            new_reg       <= 1'b0;
            need_reg      <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                new_reg  <= new_plane;
                need_reg <= !new_plane && (points_reg >= 2'd2);
                last_reg <= last_point;
                if (new_plane)
                begin
                    points_reg <= 2'd1;
                    area_reg   <= '0;
                end
            end
            if (cmd.accum)
                area_reg <= (area_sum > ACC_W'(AREA_MAX)) ? AREA_MAX
                                                          : area_sum[AREA_BITS-1:0];
            if (cmd.advance && points_reg != 2'd3)
                points_reg <= points_reg + 2'd1;
            if (cmd.verdict)
            begin
                points_reg    <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cur_x_reg <= px;
            cur_y_reg <= py;
            if (new_plane)
            begin
                anchor_x_reg <= px;
                anchor_y_reg <= py;
                prev_x_reg   <= px;
                prev_y_reg   <= py;
                held_nz_reg  <= normal_z;
                held_cz_reg  <= centre_z;
                held_e1_reg  <= extent_one;
                held_e2_reg  <= extent_two;
            end
        end
        if (cmd.advance)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (cmd.sq_x || cmd.sq_y || cmd.prod1 || cmd.prod2 || cmd.prod3)
            mul_reg <= product;
        if (cmd.sq_y || cmd.prod2)
            hold_reg <= mul_reg[MUL_W-1:0];
        if (cmd.side_save)
        begin
            case (cmd.side)
                SIDE_A:  side_a_reg <= sq_root[SIDE_W-1:0];
                SIDE_B:  side_b_reg <= sq_root[SIDE_W-1:0];
                default: side_c_reg <= sq_root[SIDE_W-1:0];
            endcase
        end
        if (cmd.terms)
        begin
            s_reg    <= ts[MAG_W-1:0];
            m1_reg   <= a1[MAG_W-1:0];
            m2_reg   <= a2[MAG_W-1:0];
            m3_reg   <= a3[MAG_W-1:0];
            zero_reg <= (t1 == '0) || (t2 == '0) || (t3 == '0);
            neg_reg  <= t1[TERM_W-1] ^ t2[TERM_W-1] ^ t3[TERM_W-1];
        end
        if (cmd.verdict)
        begin
            acc_out_reg    <= reason == REASON_NONE;
            reason_out_reg <= reason;
            area_out_reg   <= OUT_AREA_W'(area_reg);
        end
    end

    // status to the controller
    always_comb
    begin
        status.new_plane = new_reg;
        status.need_tri  = need_reg;
        status.last      = last_reg;
        status.sq_done   = sq_done;
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = acc_out_reg;
    assign reject_reason = reason_out_reg;
    assign plane_area    = area_out_reg;

endmodule

`default_nettype wire

[rtl/ptc_ctrl.sv]
// ----------------------------------------------------------------------------
// ptc_ctrl
// Controller: sequences the three side roots, the Heron product and the area
// root for each point that closes a triangle, and the verdict for each point that ends a plane.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_ctrl
    import ptc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire status_t status,
    output logic         in_ready,
    output cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DISPATCH  = 4'd1;
    localparam logic [3:0] ST_SIDE_X    = 4'd2;
    localparam logic [3:0] ST_SIDE_Y    = 4'd3;
    localparam logic [3:0] ST_SIDE_ROOT = 4'd4;
    localparam logic [3:0] ST_SIDE_WAIT = 4'd5;
    localparam logic [3:0] ST_TERMS     = 4'd6;
    localparam logic [3:0] ST_PROD1     = 4'd7;
    localparam logic [3:0] ST_PROD2     = 4'd8;
    localparam logic [3:0] ST_PROD3     = 4'd9;
    localparam logic [3:0] ST_HROOT     = 4'd10;
    localparam logic [3:0] ST_HWAIT     = 4'd11;
    localparam logic [3:0] ST_ADVANCE   = 4'd12;
    localparam logic [3:0] ST_VERDICT   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] side_reg, side_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        cmd        = '0;
        cmd.side   = side_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                side_next = SIDE_A;
                if (status.new_plane)
                    state_next = status.last ? ST_VERDICT : ST_IDLE;
                else if (status.need_tri)
                    state_next = ST_SIDE_X;
                else
                    state_next = ST_ADVANCE;
            end
            ST_SIDE_X:
            begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SIDE_Y;
            end
            ST_SIDE_Y:
            begin
                cmd.sq_y   = 1'b1;
                state_next = ST_SIDE_ROOT;
            end
            ST_SIDE_ROOT:
            begin
                cmd.side_root = 1'b1;
                state_next    = ST_SIDE_WAIT;
            end
            ST_SIDE_WAIT:
            begin
                if (status.sq_done)
                begin
                    cmd.side_save = 1'b1;
                    if (side_reg == SIDE_C)
                    begin
                        state_next = ST_TERMS;
                    end
                    else
                    begin
                        side_next  = side_reg + 2'd1;
                        state_next = ST_SIDE_X;
                    end
                end
            end
            ST_TERMS:
            begin
                cmd.terms  = 1'b1;
                state_next = ST_PROD1;
            end
            ST_PROD1:
            begin
                cmd.prod1  = 1'b1;
                state_next = ST_PROD2;
            end
            ST_PROD2:
            begin
                cmd.prod2  = 1'b1;
                state_next = ST_PROD3;
            end
            ST_PROD3:
            begin
                cmd.prod3  = 1'b1;
                state_next = ST_HROOT;
            end
            ST_HROOT:
            begin
                cmd.heron_root = 1'b1;
                state_next     = ST_HWAIT;
            end
            ST_HWAIT:
            begin
                if (status.sq_done)
                begin
                    cmd.accum  = 1'b1;
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE:
            begin
                cmd.advance = 1'b1;
                state_next  = status.last ? ST_VERDICT : ST_IDLE;
            end
            ST_VERDICT:
            begin
                if (status.out_free)
                begin
                    cmd.verdict = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            side_reg  <= SIDE_A;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

endmodule

`default_nettype wire

[rtl/plane_table_classifier.sv]
// A first or second point only updates the plane state; a later point also has
// three side roots, three products and an area root on the one shared root
// unit, and a point that closes the plane ends with the verdict. A new point is
// taken only once the last one is through; the verdict register lets the next
// point enter while a verdict waits. Reset clears all control state and
// loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// plane_table_classifier
// Sums the triangle fan Heron area of a plane hull and decides whether the
// plane is a table by tilt, height, area and extent ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module plane_table_classifier
    import ptc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    ptc_point_if.sink      point,
    ptc_verdict_if.source  verdict,
    ptc_cfg_if.sink        cfg
);

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign point.ready = in_ready;
    assign cfg.ready   = 1'b1;

    // controller
    ptc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (point.valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // datapath
    ptc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .point_x       (point.point_x),
        .point_y       (point.point_y),
        .first_point   (point.first_point),
        .last_point    (point.last_point),
        .normal_z      (point.normal_z),
        .centre_z      (point.centre_z),
        .extent_one    (point.extent_one),
        .extent_two    (point.extent_two),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.reg_index),
        .cfg_data      (cfg.write_data),
        .out_ready     (verdict.ready),
        .status        (status),
        .out_valid     (verdict.valid),
        .accepted      (verdict.accepted),
        .reject_reason (verdict.reject_reason),
        .plane_area    (verdict.plane_area)
    );

    // a verdict is loaded only into a free output word
    a_verdict_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.verdict |-> (!verdict.valid || verdict.ready))
        else $error("verdict overwrote a pending word");

    // a new word appears only after a verdict command
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(verdict.valid) |-> $past(cmd.verdict))
        else $error("output valid without verdict");

    // one multiplier op at a time
    a_mul_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.sq_x, cmd.sq_y, cmd.prod1, cmd.prod2, cmd.prod3}))
        else $error("multiplier claimed twice");

    // a point is taken only when the controller is ready
    a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> (in_ready && point.valid))
        else $error("point taken without handshake");

endmodule

`default_nettype wire

[verif/plane_table_classifier_test.sv]
// ----------------------------------------------------------------------------
// plane_table_classifier_test
// Drives hull points and register writes into the plane table classifier,
// predicts each verdict with an integer Heron fan model and compares every
// word on the verdict channel against the predicted verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module plane_table_classifier_test;
    import ptc_pkg::*;

    localparam int LIMIT_CYCLES = 900000;

    // indexes past the register list, writes are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                     first;
        logic                     last;
        logic signed [XY_W-1:0]   px;
        logic signed [XY_W-1:0]   py;
        logic signed [ATTR_W-1:0] nz;
        logic signed [ATTR_W-1:0] cz;
        logic [ATTR_W-1:0]        e1;
        logic [ATTR_W-1:0]        e2;
    } point_word_t;

    typedef struct packed {
        logic                  acc;
        logic [REASON_W-1:0]   reason;
        logic [OUT_AREA_W-1:0] area;
    } verdict_word_t;

    // directed row: point plus an optional typed-in verdict
    typedef struct packed {
        point_word_t   pw;
        logic          fixed;
        verdict_word_t vw;
    } plane_row_t;

    logic clk;
    logic rst_n;

    ptc_point_if   point_ch ();
    ptc_verdict_if verdict_ch ();
    ptc_cfg_if     cfg_ch ();

    plane_table_classifier u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .point   (point_ch),
        .verdict (verdict_ch),
        .cfg     (cfg_ch)
    );

    // predictor copy of registers and state
    logic [14:0]          thr_nz;
    logic signed [13:0]   cam_off;
    logic signed [15:0]   h_lo;
    logic signed [15:0]   h_hi;
    logic [31:0]          area_lo;
    logic [8:0]           ratio_lo;
    logic signed [XY_W-1:0] anc_x, anc_y, prv_x, prv_y;
    int unsigned          pts_open;
    logic [AREA_BITS:0]   fan_area;
    logic signed [15:0]   hold_nz, hold_cz;
    logic [15:0]          hold_e1, hold_e2;

    verdict_word_t verdicts_due[$];
    int  mismatches;
    bit  failed;
    bit  quiet;
    longint cycle_count;

    // clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint edge_len(input longint x0, y0, x1, y1);
        longint dx;
        longint dy;
        dx = x1 - x0;
        dy = y1 - y0;
        return longint'(int_root(64'(dx * dx + dy * dy)));
    endfunction

    function automatic logic [63:0] heron_area(input longint x0, y0, x1, y1,
                                               input longint x2, y2);
        longint a;
        longint b;
        longint c;
        longint p;
        a = edge_len(x0, y0, x1, y1);
        b = edge_len(x0, y0, x2, y2);
        c = edge_len(x1, y1, x2, y2);
        p = (a + b + c) * (b + c - a) * (a + c - b) * (a + b - c);
        if (p < 0)
            p = 0;
        return int_root(64'(p)) >> 2;
    endfunction

    task automatic predictor_reset();
        thr_nz   = 15'd31164;
        cam_off  = '0;
        h_lo     = 16'sd563;
        h_hi     = 16'sd1126;
        area_lo  = 32'd314573;
        ratio_lo = 9'd64;
        anc_x = '0; anc_y = '0; prv_x = '0; prv_y = '0;
        pts_open = 0;
        fan_area = '0;
        hold_nz = '0; hold_cz = '0; hold_e1 = '0; hold_e2 = '0;
    endtask

    task automatic predictor_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [31:0] d);
        case (idx)
            REG_MIN_NORMAL_Z:  thr_nz   = d[14:0];
            REG_CAMERA_OFFSET: cam_off  = d[13:0];
            REG_MIN_HEIGHT:    h_lo     = d[15:0];
            REG_MAX_HEIGHT:    h_hi     = d[15:0];
            REG_MIN_AREA:      area_lo  = d;
            REG_MIN_RATIO:     ratio_lo = d[8:0];
            default: ;
        endcase
    endtask

    // advance the plane state by one point; returns 1 with a verdict on a last point
    function automatic bit classify_point(input point_word_t pw,
                                          output verdict_word_t vw);
        longint absnz;
        longint hgt;
        longint mn;
        longint mx;
        logic [REASON_W-1:0] why;
        logic [AREA_BITS:0] sum;
        if (pw.first || pts_open == 0)
        begin
            hold_nz = pw.nz; hold_cz = pw.cz; hold_e1 = pw.e1; hold_e2 = pw.e2;
            anc_x = pw.px; anc_y = pw.py; prv_x = pw.px; prv_y = pw.py;
            pts_open = 1;
            fan_area = '0;
        end
        else
        begin
            if (pts_open >= 2)
            begin
                sum = (AREA_BITS+1)'(fan_area
                      + heron_area(anc_x, anc_y, prv_x, prv_y, pw.px, pw.py));
                fan_area = (sum > {1'b0, AREA_MAX}) ? {1'b0, AREA_MAX} : sum;
            end
            prv_x = pw.px; prv_y = pw.py;
            if (pts_open < 3)
                pts_open++;
        end
        if (!pw.last)
            return 0;
        absnz = (hold_nz < 0) ? -longint'(hold_nz) : longint'(hold_nz);
        hgt = longint'(cam_off) + longint'(hold_cz);
        mn = (hold_e1 > hold_e2) ? hold_e2 : hold_e1;
        mx = (hold_e1 > hold_e2) ? hold_e1 : hold_e2;
        if (absnz < longint'(thr_nz))
            why = REASON_TILT;
        else if (hgt < h_lo || hgt > h_hi)
            why = REASON_HEIGHT;
        else if (fan_area < area_lo)
            why = REASON_AREA;
        else if (mx == 0 || mn * 256 < longint'(ratio_lo) * mx)
            why = REASON_RATIO;
        else
            why = REASON_NONE;
        vw.acc = (why == REASON_NONE);
        vw.reason = why;
        vw.area = fan_area[OUT_AREA_W-1:0];
        pts_open = 0;
        return 1;
    endfunction

    // drive one point word and record its expected verdict
    task automatic send_point(input point_word_t pw, input bit fixed,
                              input verdict_word_t fv);
        verdict_word_t vw;
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            point_ch.valid <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(negedge clk);
        end
        point_ch.valid       <= 1'b1;
        point_ch.first_point <= pw.first;
        point_ch.last_point  <= pw.last;
        point_ch.point_x     <= pw.px;
        point_ch.point_y     <= pw.py;
        point_ch.normal_z    <= pw.nz;
        point_ch.centre_z    <= pw.cz;
        point_ch.extent_one  <= pw.e1;
        point_ch.extent_two  <= pw.e2;
        if (classify_point(pw, vw))
        begin
            verdicts_due.insert(verdicts_due.size(), fixed ? fv : vw);
            if (fixed && fv != vw)
            begin
                failed = 1;
                $display("table row disagrees with predictor exp=%h pred=%h", fv, vw);
            end
        end
        do @(posedge clk); while (!point_ch.ready);
        @(negedge clk);
    endtask

    // register write while idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.reg_index  <= idx;
        cfg_ch.write_data <= d;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        predictor_write(idx, d);
        @(negedge clk);
    endtask

    task automatic drain();
        point_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    function automatic point_word_t mk(input bit f, l, input int x, y,
                                       input int nz, cz, e1, e2);
        point_word_t pw;
        pw.first = f; pw.last = l; pw.px = XY_W'(x); pw.py = XY_W'(y);
        pw.nz = ATTR_W'(nz); pw.cz = ATTR_W'(cz);
        pw.e1 = ATTR_W'(e1); pw.e2 = ATTR_W'(e2);
        return pw;
    endfunction

    function automatic point_word_t rand_attr(input point_word_t pw);
        pw.nz = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(30000, 32767));
        if ($urandom_range(0, 1)) pw.nz = -pw.nz;
        pw.cz = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(500, 1200));
        pw.e1 = 16'($urandom);
        pw.e2 = $urandom_range(0, 3) == 0 ? 16'($urandom) : pw.e1 - 16'($urandom_range(0, 9000));
        return pw;
    endfunction

    // random plane: a well-formed hull walk or noise
    task automatic random_plane(input int max_pts);
        int n;
        int k;
        int r;
        point_word_t pw;
        verdict_word_t none;
        none = '0;
        n = $urandom_range(1, max_pts);
        r = $urandom_range(0, 3) == 0 ? 4095 : $urandom_range(50, 1500);
        for (k = 0; k < n; k++)
        begin
            pw = rand_attr('0);
            if ($urandom_range(0, 5) == 0)
            begin
                pw.px = 13'($urandom);
                pw.py = 13'($urandom);
            end
            else
            begin
                pw.px = 13'($signed($urandom_range(0, 2 * r)) - r);
                pw.py = 13'($signed($urandom_range(0, 2 * r)) - r);
            end
            pw.first = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 40) == 0);
            pw.last  = (k == n - 1) ? ($urandom_range(0, 12) != 0) : 1'b0;
            send_point(pw, 0, none);
        end
    endtask

    // verdict sink with random stalls
    initial
    begin
        verdict_word_t exp;
        verdict_word_t got;
        int stall;
        verdict_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                verdict_ch.ready <= 1'b0;
                stall = $urandom_range(1, 11);
                repeat (stall) @(negedge clk);
            end
            verdict_ch.ready <= 1'b1;
            @(posedge clk);
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                got.acc    = verdict_ch.accepted;
                got.reason = verdict_ch.reject_reason;
                got.area   = verdict_ch.plane_area;
                if (verdicts_due.size() == 0)
                begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected verdict %h", got);
                end
                else
                begin
                    exp = verdicts_due.pop_front();
                    if (got !== exp)
                    begin
                        failed = 1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"verdict mismatch exp acc=%0d why=%0d area=%0d",
                                      " got acc=%0d why=%0d area=%0d"},
                                     exp.acc, exp.reason, exp.area,
                                     got.acc, got.reason, got.area);
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        plane_row_t rows[$];
        plane_row_t row;
        verdict_word_t none;
        int i;
        int ph;
        none = '0;
        cycle_count = 0;
        mismatches = 0;
        failed = 0;
        quiet = 0;
        rst_n = 1'b0;
        point_ch.valid = 1'b0;
        point_ch.first_point = 1'b0;
        point_ch.last_point = 1'b0;
        point_ch.point_x = '0;
        point_ch.point_y = '0;
        point_ch.normal_z = '0;
        point_ch.centre_z = '0;
        point_ch.extent_one = '0;
        point_ch.extent_two = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.write_data = '0;
        predictor_reset();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table: fixed verdicts where obvious, else predictor
        // one point plane, tilt at reset thresholds
        rows.insert(rows.size(), {mk(1, 1, 0, 0, 0, 800, 100, 100), 1'b1,
                                  {1'b0, REASON_TILT, 32'd0}});
        // full negative normal, height too low
        rows.insert(rows.size(), {mk(1, 1, 5, 5, -32768, -32768, 1, 1), 1'b1,
                                  {1'b0, REASON_HEIGHT, 32'd0}});
        // two points: area zero, so area rejects
        rows.insert(rows.size(), {mk(1, 0, 0, 0, 32767, 800, 100, 100), 1'b0, none});
        rows.insert(rows.size(), {mk(0, 1, 4095, 4095, 0, 0, 0, 0), 1'b1,
                                  {1'b0, REASON_AREA, 32'd0}});
        // large triangle at the coordinate extremes
        rows.insert(rows.size(), {mk(1, 0, -4096, -4096, 32767, 800, 65535, 65535), 1'b0, none});
        rows.insert(rows.size(), {mk(0, 0, 4095, -4096, 0, 0, 0, 0), 1'b0, none});
        rows.insert(rows.size(), {mk(0, 1, 4095, 4095, 0, 0, 0, 0), 1'b0, none});
        // zero maximum extent with a big square
        rows.insert(rows.size(), {mk(1, 0, -4096, -4096, -32768, 1126, 0, 0), 1'b0, none});
        rows.insert(rows.size(), {mk(0, 0, 4095, -4096, 0, 0, 0, 0), 1'b0, none});
        rows.insert(rows.size(), {mk(0, 0, 4095, 4095, 0, 0, 0, 0), 1'b0, none});
        rows.insert(rows.size(), {mk(0, 1, -4096, 4095, 0, 0, 0, 0), 1'b0, none});
        // collinear points, plane abandoned by a new first point
        rows.insert(rows.size(), {mk(1, 0, 0, 0, 32767, 563, 65535, 0), 1'b0, none});
        rows.insert(rows.size(), {mk(0, 0, 10, 10, 0, 0, 0, 0), 1'b0, none});
        rows.insert(rows.size(), {mk(1, 0, 0, 0, 32767, 563, 200, 800), 1'b0, none});
        rows.insert(rows.size(), {mk(0, 0, 2000, 0, 0, 0, 0, 0), 1'b0, none});
        rows.insert(rows.size(), {mk(0, 0, 2000, 2000, 0, 0, 0, 0), 1'b0, none});
        rows.insert(rows.size(), {mk(0, 1, 0, 2000, 0, 0, 0, 0), 1'b0, none});
        // point with no open plane acts as first
        rows.insert(rows.size(), {mk(0, 1, 1, 1, 31164, 1126, 7, 3), 1'b1,
                                  {1'b0, REASON_AREA, 32'd0}});
        foreach (rows[i])
        begin
            row = rows[i];
            send_point(row.pw, row.fixed, row.vw);
        end
        drain();

        // register extremes, then random settings between phases
        write_reg(REG_MIN_NORMAL_Z, 32'h0);
        write_reg(REG_CAMERA_OFFSET, 32'h2000);
        write_reg(REG_MIN_HEIGHT, 32'h8000);
        write_reg(REG_MAX_HEIGHT, 32'h7FFF);
        write_reg(REG_MIN_AREA, 32'h0);
        write_reg(REG_MIN_RATIO, 32'h1FF);
        write_reg(REG_SPARE_LO, 32'hFFFFFFFF);
        write_reg(REG_SPARE_HI, 32'h0);
        for (i = 0; i < 6; i++)
            send_point(mk(i == 0, i == 5, i * 700 - 1500, (i % 3) * 1200, 0, 0, 9, 9), 0, none);
        drain();
        write_reg(REG_MIN_NORMAL_Z, 32'h7FFF);
        write_reg(REG_CAMERA_OFFSET, 32'h1FFF);
        write_reg(REG_MIN_HEIGHT, 32'h0);
        write_reg(REG_MAX_HEIGHT, 32'hFFFF);
        write_reg(REG_MIN_AREA, 32'hFFFFFFFF);
        write_reg(REG_MIN_RATIO, 32'h100);
        random_plane(6);
        random_plane(6);
        drain();

        for (ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_MIN_NORMAL_Z, $urandom_range(28000, 32767));
            write_reg(REG_CAMERA_OFFSET,
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300));
            write_reg(REG_MIN_HEIGHT, $urandom_range(300, 700));
            write_reg(REG_MAX_HEIGHT, $urandom_range(900, 1500));
            write_reg(REG_MIN_AREA,
                      $urandom_range(0, 1) ? $urandom_range(0, 3000000) : $urandom);
            write_reg(REG_MIN_RATIO, $urandom_range(0, 300));
            if (ph == 4)
                quiet = 1;
            for (i = 0; i < 24; i++)
                random_plane(9);
            drain();
        end
        if (!failed && mismatches == 0 && verdicts_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

`default_nettype wire

[files.f]
rtl/ptc_pkg.sv
rtl/ptc_point_if.sv
rtl/ptc_verdict_if.sv
rtl/ptc_cfg_if.sv
rtl/ptc_sqrt.sv
rtl/ptc_dp.sv
rtl/ptc_ctrl.sv
rtl/plane_table_classifier.sv
verif/plane_table_classifier_test.sv
